// ===== design/cpxm_pkg.sv =====
// ----------------------------------------------------------------------------
// cpxm_pkg
// shared widths, reset values and state encoding for the collision pair
// xor merger
// ----------------------------------------------------------------------------
package cpxm_pkg;

    localparam int ITEM_BITS   = 200;
    localparam int MERGED_BITS = 180;
    localparam int S_TDATA_W   = 200;
    localparam int M_TDATA_W   = 184;
    localparam int LIMIT_BITS  = 23;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 23'd2097152;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_PAIR = 2'b10
    } state_t;

endpackage

// ===== design/cpxm_pair_store.sv =====
// ----------------------------------------------------------------------------
// cpxm_pair_store
// group store with one write and one registered read port; xors the word
// read back with the held item and drops the key bits
// ----------------------------------------------------------------------------
module cpxm_pair_store #(
    parameter int GROUP_DEPTH = 16,
    parameter int KEY_BITS    = 20,
    parameter int IDX_W       = 4
) (
    input  logic                              aclk,
    input  logic                              wr_en,
    input  logic [IDX_W-1:0]                  wr_addr,
    input  logic [cpxm_pkg::ITEM_BITS-1:0]    wr_item,
    input  logic [IDX_W-1:0]                  rd_addr,
    input  logic [cpxm_pkg::ITEM_BITS-1:0]    pair_item,
    output logic [cpxm_pkg::MERGED_BITS-1:0]  merged
);

    logic [cpxm_pkg::ITEM_BITS-1:0] mem [GROUP_DEPTH];
    logic [cpxm_pkg::ITEM_BITS-1:0] rd_item_reg;
    logic [cpxm_pkg::ITEM_BITS-1:0] pair_xor;
    logic [cpxm_pkg::ITEM_BITS-1:0] pair_shifted;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_item;
        end
        rd_item_reg <= mem[rd_addr];
    end

    assign pair_xor     = rd_item_reg ^ pair_item;
    assign pair_shifted = pair_xor >> KEY_BITS;
    assign merged       = pair_shifted[cpxm_pkg::MERGED_BITS-1:0];

endmodule

// ===== design/collision_pair_xor_merger_unit.sv =====
// ----------------------------------------------------------------------------
// collision_pair_xor_merger_unit
// pairs each item with the stored items of its equal-key group and emits
// the xor of every pair, up to the output limit, with the key bits dropped
// ----------------------------------------------------------------------------
// input words arrive on s_ sorted by key; s_tlast marks the end of a list
// a word whose key matches the open group is paired with every stored item,
// oldest first, until the output limit is met, one result word per cycle on
// m_; m_tlast marks the last result of an input word, m_tuser flags that the
// input found the store full; an input word that opens a group, or meets the
// output limit, gives no result; a word with results holds off new input
// until its last result is registered; the user must write output_limit through
// cfg_wr_en / cfg_wr_data only while idle, which the block does not enforce
// reset empties the group, clears the emitted count and restores the limit
// when m_tready is low the result waits in the output register and the pair
// loop holds; a new input word is taken while the last result still waits
// ----------------------------------------------------------------------------
module collision_pair_xor_merger_unit #(
    parameter int GROUP_DEPTH = 16,
    parameter int KEY_BITS    = 20
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [cpxm_pkg::LIMIT_BITS-1:0]     cfg_wr_data,   // output_limit
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // item_bits_low, item_bits_mid, item_bits_high, item_top_byte
    input  logic [cpxm_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                                s_tlast,       // list_end
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // merged_low, merged_mid, merged_high, zero pad
    output logic [cpxm_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast,       // run_last
    output logic                                m_tuser        // group_overflow
);

    localparam int IDX_W = $clog2(GROUP_DEPTH);

    cpxm_pkg::state_t state_reg, state_next;

    logic [cpxm_pkg::LIMIT_BITS-1:0] limit_reg;
    logic [cpxm_pkg::LIMIT_BITS-1:0] emitted_reg, emitted_next;
    logic [KEY_BITS-1:0]             key_reg, key_next;
    logic [IDX_W-1:0]                fill_reg, fill_next;
    logic [IDX_W-1:0]                idx_reg, idx_next;
    logic [IDX_W-1:0]                npairs_reg, npairs_next;
    logic                            ovf_reg, ovf_next;
    logic                            end_reg, end_next;
    logic                            m_valid_reg, m_valid_next;
    logic [cpxm_pkg::ITEM_BITS-1:0]  item_reg;
    logic [cpxm_pkg::MERGED_BITS-1:0] m_data_reg;
    logic                            m_last_reg;
    logic                            m_user_reg;

    logic                            accept;
    logic [cpxm_pkg::ITEM_BITS-1:0]  in_item;
    logic [KEY_BITS-1:0]             in_key;
    logic                            same_group;
    logic                            store_full;
    logic                            has_pairs;
    logic                            emit_ok;
    logic                            step;
    logic                            last_pair;
    logic                            wr_en;
    logic [IDX_W-1:0]                wr_addr;
    logic [IDX_W-1:0]                rd_addr;
    logic [cpxm_pkg::MERGED_BITS-1:0] merged;

    assign s_tready   = (state_reg == cpxm_pkg::ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign in_item    = s_tdata[cpxm_pkg::ITEM_BITS-1:0];
    assign in_key     = s_tdata[KEY_BITS-1:0];
    assign same_group = (fill_reg != '0) && (in_key == key_reg);
    assign store_full = (fill_reg >= IDX_W'(GROUP_DEPTH - 1));
    assign has_pairs  = same_group && (emitted_reg < limit_reg);

    assign emit_ok   = !m_valid_reg || m_tready;
    assign step      = (state_reg == cpxm_pkg::ST_PAIR) && emit_ok;
    assign last_pair = (idx_reg == (npairs_reg - IDX_W'(1)))
                    || ((emitted_reg + cpxm_pkg::LIMIT_BITS'(1)) == limit_reg);

    assign wr_en   = accept && (!same_group || !store_full);
    assign wr_addr = same_group ? fill_reg : '0;
    assign rd_addr = step ? (idx_reg + IDX_W'(1)) : idx_reg;

    cpxm_pair_store #(
        .GROUP_DEPTH (GROUP_DEPTH),
        .KEY_BITS    (KEY_BITS),
        .IDX_W       (IDX_W)
    ) u_store (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_item   (in_item),
        .rd_addr   (rd_addr),
        .pair_item (item_reg),
        .merged    (merged)
    );

    always_comb begin
        state_next   = state_reg;
        emitted_next = emitted_reg;
        key_next     = key_reg;
        fill_next    = fill_reg;
        idx_next     = idx_reg;
        npairs_next  = npairs_reg;
        ovf_next     = ovf_reg;
        end_next     = end_reg;
        m_valid_next = m_valid_reg && !m_tready;

        case (state_reg)
            cpxm_pkg::ST_IDLE: begin
                if (accept) begin
                    ovf_next    = same_group && store_full;
                    npairs_next = fill_reg;
                    idx_next    = '0;
                    end_next    = s_tlast;
                    if (!same_group) begin
                        key_next  = in_key;
                        fill_next = IDX_W'(1);
                    end else if (!store_full) begin
                        fill_next = fill_reg + IDX_W'(1);
                    end
                    if (has_pairs) begin
                        state_next = cpxm_pkg::ST_PAIR;
                    end else if (s_tlast) begin
                        emitted_next = '0;
                    end
                    if (s_tlast) begin
                        fill_next = '0;
                    end
                end
            end
            cpxm_pkg::ST_PAIR: begin
                if (emit_ok) begin
                    m_valid_next = 1'b1;
                    emitted_next = emitted_reg + cpxm_pkg::LIMIT_BITS'(1);
                    idx_next     = idx_reg + IDX_W'(1);
                    if (last_pair) begin
                        state_next = cpxm_pkg::ST_IDLE;
                        idx_next   = '0;
                        if (end_reg) begin
                            emitted_next = '0;
                        end
                    end
                end
            end
            default: begin
                state_next = cpxm_pkg::ST_IDLE;
                idx_next   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cpxm_pkg::ST_IDLE;
            limit_reg   <= cpxm_pkg::LIMIT_RESET;
            emitted_reg <= '0;
            key_reg     <= '0;
            fill_reg    <= '0;
            idx_reg     <= '0;
            npairs_reg  <= '0;
            ovf_reg     <= 1'b0;
            end_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            emitted_reg <= emitted_next;
            key_reg     <= key_next;
            fill_reg    <= fill_next;
            idx_reg     <= idx_next;
            npairs_reg  <= npairs_next;
            ovf_reg     <= ovf_next;
            end_reg     <= end_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= in_item;
        end
        if (step) begin
            m_data_reg <= merged;
            m_last_reg <= last_pair;
            m_user_reg <= ovf_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(cpxm_pkg::M_TDATA_W - cpxm_pkg::MERGED_BITS){1'b0}}, m_data_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule
